// File: sv/linear_upsampler_2x_4x_defines.svh
// Assertion macros for the linear upsampler.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef LINEAR_UPSAMPLER_2X_4X_DEFINES_SVH
`define LINEAR_UPSAMPLER_2X_4X_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define LU24_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define LU24_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LU24_ASSERT_SAME(lbl, ante, cons, msg)
`define LU24_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/lu24_pkg.sv
`default_nettype none

package lu24_pkg;

  // Job queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam logic [QCntW-1:0] QDepthCnt = QCntW'(QDepth);

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    CfgRate     = 2'd0,
    CfgSrcWide  = 2'd1,
    CfgOutWide  = 2'd2
  } lu24_cfg_idx_e;

  // Rate factor codes; the unused code behaves as 4x
  typedef enum logic [1:0] {
    Rate1x = 2'd0,
    Rate2x = 2'd1,
    Rate4x = 2'd2
  } lu24_rate_e;

  // One classified sample, ready for the back end to play out
  typedef struct packed {
    logic [15:0] first;   // held sample, offset domain
    logic [15:0] q1;      // quarter point
    logic [15:0] mid;     // midpoint
    logic [15:0] q3;      // three-quarter point
    logic [15:0] cur;     // new sample, offset domain
    logic        has_run; // emit the interpolated run from the held sample
    logic        fin;     // emit the final repeats
    logic [1:0]  rate;
    logic        wide;    // 16-bit signed output
  } lu24_job_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } lu24_q_stat_t;

  typedef struct packed {
    logic held_valid;
  } lu24_fe_stat_t;

  // Raw bits to the offset domain under the current format
  function automatic logic [15:0] to_domain(logic [15:0] raw, logic src_wide,
                                            logic out_wide);
    logic [15:0] v;
    if (src_wide) begin
      v = raw ^ 16'h8000;
    end else if (out_wide) begin
      v = {raw[7:0], 8'h00};
    end else begin
      v = {8'h00, raw[7:0]};
    end
    return v;
  endfunction

  // Offset domain back to output bits
  function automatic logic [15:0] from_domain(logic [15:0] v, logic wide);
    return wide ? (v ^ 16'h8000) : {8'h00, v[7:0]};
  endfunction

  // Floor average of two offset-domain values
  function automatic logic [15:0] avg(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16:1];
  endfunction

endpackage

`default_nettype wire

// File: sv/lu24_if.sv
`default_nettype none

// Sample input channel
interface lu24_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_bits;
  logic        is_final;

  modport source (output valid, output sample_bits, output is_final, input ready);
  modport sink   (input valid, input sample_bits, input is_final, output ready);
endinterface

// Result output channel
interface lu24_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_bits;
  logic        run_end;

  modport source (output valid, output out_bits, output run_end, input ready);
  modport sink   (input valid, input out_bits, input run_end, output ready);
endinterface

// Configuration write channel
interface lu24_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/lu24_front.sv
`default_nettype none

module lu24_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lu24_in_if.sink                in_ch,
  lu24_cfg_if.sink               cfg_ch,
  output lu24_pkg::lu24_job_t    job_o,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output lu24_pkg::lu24_fe_stat_t stat_o
);

  logic [1:0]  rate_q;
  logic        src_wide_q;
  logic        out_wide_q;
  logic [15:0] held_q, held_d;
  logic        held_valid_q, held_valid_d;
  logic        accept;
  logic [15:0] first, cur, mid;

  // Configuration registers, always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= 2'd0;
      src_wide_q <= 1'b0;
      out_wide_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (lu24_pkg::lu24_cfg_idx_e'(cfg_ch.index))
        lu24_pkg::CfgRate:    rate_q     <= cfg_ch.data;
        lu24_pkg::CfgSrcWide: src_wide_q <= cfg_ch.data[0];
        lu24_pkg::CfgOutWide: out_wide_q <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Take a beat whenever the queue has room
  assign in_ch.ready = push_ready_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify: interpolation points and repeat flags
  assign first = lu24_pkg::to_domain(held_q, src_wide_q, out_wide_q);
  assign cur   = lu24_pkg::to_domain(in_ch.sample_bits, src_wide_q, out_wide_q);
  assign mid   = lu24_pkg::avg(first, cur);

  always_comb begin
    job_o.first   = first;
    job_o.q1      = lu24_pkg::avg(first, mid);
    job_o.mid     = mid;
    job_o.q3      = lu24_pkg::avg(mid, cur);
    job_o.cur     = cur;
    job_o.has_run = held_valid_q;
    job_o.fin     = in_ch.is_final;
    job_o.rate    = rate_q;
    job_o.wide    = src_wide_q | out_wide_q;
  end

  // A first sample that is not final produces nothing
  assign push_valid_o = in_ch.valid && (held_valid_q || in_ch.is_final);

  // Hold the previous sample; drop it after the final one
  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    if (accept) begin
      if (in_ch.is_final) begin
        held_d       = 16'h0000;
        held_valid_d = 1'b0;
      end else begin
        held_d       = in_ch.sample_bits;
        held_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= 16'h0000;
      held_valid_q <= 1'b0;
    end else begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
    end
  end

  assign stat_o.held_valid = held_valid_q;

endmodule

`default_nettype wire

// File: sv/lu24_queue.sv
`default_nettype none

module lu24_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lu24_pkg::lu24_job_t     push_job_i,
  input  logic                    push_valid_i,
  output logic                    push_ready_o,
  output lu24_pkg::lu24_job_t     head_job_o,
  output logic                    head_valid_o,
  input  logic                    pop_i,
  output lu24_pkg::lu24_q_stat_t  stat_o
);

  lu24_pkg::lu24_job_t mem_q [lu24_pkg::QDepth];
  logic [lu24_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [lu24_pkg::QCntW-1:0] count_q;
  logic full, empty, do_push, do_pop;

  assign full    = (count_q == lu24_pkg::QDepthCnt);
  assign empty   = (count_q == '0);
  assign do_push = push_valid_i && !full;
  assign do_pop  = pop_i && !empty;

  // Wrap a pointer at the queue depth
  function automatic logic [lu24_pkg::QPtrW-1:0] next_ptr(
      logic [lu24_pkg::QPtrW-1:0] p);
    logic [lu24_pkg::QPtrW-1:0] n;
    if (p == lu24_pkg::QPtrW'(lu24_pkg::QDepth - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign push_ready_o = !full;
  assign head_job_o   = mem_q[rd_ptr_q];
  assign head_valid_o = !empty;

  assign stat_o.count = count_q;
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

endmodule

`default_nettype wire

// File: sv/lu24_back.sv
`default_nettype none

module lu24_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lu24_pkg::lu24_job_t head_job_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  lu24_out_if.source          out_ch
);

  logic [2:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_bits_q;
  logic        run_end_q;
  logic [3:0]  run_len, total;
  logic        last, in_run, adv;
  logic [15:0] sel;

  // Results per segment from the rate code
  always_comb begin
    unique case (lu24_pkg::lu24_rate_e'(head_job_i.rate))
      lu24_pkg::Rate1x: run_len = 4'd1;
      lu24_pkg::Rate2x: run_len = 4'd2;
      default:          run_len = 4'd4;
    endcase
  end

  assign total  = (head_job_i.has_run ? run_len : 4'd0) + (head_job_i.fin ? run_len : 4'd0);
  assign last   = (({1'b0, step_q} + 4'd1) == total);
  assign in_run = head_job_i.has_run && ({1'b0, step_q} < run_len);

  // Pick the point for this step
  always_comb begin
    sel = head_job_i.cur;
    if (in_run) begin
      unique case (lu24_pkg::lu24_rate_e'(head_job_i.rate))
        lu24_pkg::Rate1x: sel = head_job_i.first;
        lu24_pkg::Rate2x: sel = step_q[0] ? head_job_i.mid : head_job_i.first;
        default: begin
          case (step_q[1:0])
            2'd0:    sel = head_job_i.first;
            2'd1:    sel = head_job_i.q1;
            2'd2:    sel = head_job_i.mid;
            default: sel = head_job_i.q3;
          endcase
        end
      endcase
    end
  end

  // Advance when the output register is free or being drained
  assign adv   = head_valid_i && (!out_valid_q || out_ch.ready);
  assign pop_o = adv && last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      step_d      = last ? 3'd0 : step_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_bits_q <= lu24_pkg::from_domain(sel, head_job_i.wide);
      run_end_q  <= head_job_i.fin && last;
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_bits = out_bits_q;
  assign out_ch.run_end  = run_end_q;

endmodule

`default_nettype wire

// File: sv/linear_upsampler_2x_4x.sv
// Path: the first result of a sample is written into the job queue, then into
// the output register, from which it leaves when no earlier job is queued.
// Throughput: one result per cycle from the single output register while the
// receiver is ready; each sample yields results according to its rate factor.
// Reset (async, active low): 1x rate, 8-bit source and output, no sample
// held, job queue empty, output register empty.
`default_nettype none

`include "linear_upsampler_2x_4x_defines.svh"

module linear_upsampler_2x_4x (
  input  logic        clk_i,
  input  logic        rst_ni,
  lu24_in_if.sink     in_ch,
  lu24_cfg_if.sink    cfg_ch,
  lu24_out_if.source  out_ch
);

  lu24_pkg::lu24_job_t     push_job, head_job;
  logic                    push_valid, push_ready;
  logic                    head_valid, pop;
  lu24_pkg::lu24_q_stat_t  q_stat;
  lu24_pkg::lu24_fe_stat_t fe_stat;

  // Accept and classify samples
  lu24_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .job_o        (push_job),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .stat_o       (fe_stat)
  );

  // Decouple front and back
  lu24_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (push_job),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .head_job_o   (head_job),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .stat_o       (q_stat)
  );

  // Play out results one beat per cycle while the receiver is ready
  lu24_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_job_i   (head_job),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

  `LU24_ASSERT_SAME(a_q_bound, 1'b1, q_stat.count <= lu24_pkg::QDepthCnt, "queue overfilled")
  `LU24_ASSERT_SAME(a_first_quiet, in_ch.valid && in_ch.ready && !in_ch.is_final && !fe_stat.held_valid, !push_valid, "job pushed for a lone first sample")
  `LU24_ASSERT_NEXT(a_final_clears, in_ch.valid && in_ch.ready && in_ch.is_final, !fe_stat.held_valid, "sample still held after final beat")
  `LU24_ASSERT_SAME(a_pop_nonempty, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  // Wait after the last result before touching the registers or ending
  localparam int unsigned SettleCycles = 8;
  // Cycles without any beat before the run is abandoned
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseItems   = 54;
  // Index beyond the register list; a write there must change nothing
  localparam logic [1:0]  CfgSpare     = 2'd3;

  typedef struct packed {
    logic [15:0] bits;
    logic        last;
  } out_sample_t;

  logic clk_i;
  logic rst_ni;

  lu24_in_if  smp_if ();
  lu24_cfg_if cfg_if ();
  lu24_out_if res_if ();

  linear_upsampler_2x_4x dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (smp_if),
    .cfg_ch (cfg_if),
    .out_ch (res_if)
  );

  // Predicted register and hold state
  logic [1:0]  pred_rate;
  logic        pred_src_wide;
  logic        pred_out_wide;
  logic [15:0] held_raw;
  logic        held_live;

  out_sample_t expected_samples[$];
  out_sample_t want;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Raw bits to the offset domain under the predicted format
  function automatic logic [15:0] to_offset(logic [15:0] raw);
    if (pred_src_wide) begin
      return raw ^ 16'h8000;
    end else if (pred_out_wide) begin
      return {raw[7:0], 8'h00};
    end
    return {8'h00, raw[7:0]};
  endfunction

  function automatic logic [15:0] floor_mid(logic [15:0] a, logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[16:1];
  endfunction

  // Convert back to output bits and queue
  task automatic queue_output(input logic [15:0] v, input logic last);
    out_sample_t s;
    if (pred_src_wide || pred_out_wide) begin
      s.bits = v ^ 16'h8000;
    end else begin
      s.bits = {8'h00, v[7:0]};
    end
    s.last = last;
    expected_samples.push_back(s);
  endtask

  // Work out the run caused by one accepted sample
  task automatic interpolate_sample(input logic [15:0] raw, input logic fin);
    int unsigned mult;
    logic [15:0] cur;
    logic [15:0] first;
    logic [15:0] mid;
    case (pred_rate)
      lu24_pkg::Rate1x: mult = 1;
      lu24_pkg::Rate2x: mult = 2;
      default:          mult = 4;
    endcase
    cur = to_offset(raw);
    if (held_live) begin
      first = to_offset(held_raw);
      mid = floor_mid(first, cur);
      queue_output(first, 1'b0);
      if (mult == 2) begin
        queue_output(mid, 1'b0);
      end else if (mult == 4) begin
        queue_output(floor_mid(first, mid), 1'b0);
        queue_output(mid, 1'b0);
        queue_output(floor_mid(mid, cur), 1'b0);
      end
    end
    if (fin) begin
      for (int unsigned i = 0; i < mult; i++) begin
        queue_output(cur, i == mult - 1);
      end
      held_live = 1'b0;
      held_raw = 16'h0000;
    end else begin
      held_live = 1'b1;
      held_raw = raw;
    end
  endtask

  // Offer one sample beat and predict on acceptance
  task automatic send_sample(input logic [15:0] bits, input logic fin);
    @(negedge clk_i);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      smp_if.valid = 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid = 1'b1;
    smp_if.sample_bits = bits;
    smp_if.is_final = fin;
    do @(posedge clk_i); while (!smp_if.ready);
    interpolate_sample(bits, fin);
  endtask

  // Write one register; only called once the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      lu24_pkg::CfgRate:    pred_rate = data;
      lu24_pkg::CfgSrcWide: pred_src_wide = data[0];
      lu24_pkg::CfgOutWide: pred_out_wide = data[0];
      default:              ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk_i);
    smp_if.valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Lone final sample with nothing held, reset settings
  task automatic test_single_final();
    send_sample(16'h00A5, 1'b1);
  endtask

  // 4x on bytes, byte extremes, upper bits ignored
  task automatic test_narrow_4x();
    wait_idle();
    write_reg(lu24_pkg::CfgRate, lu24_pkg::Rate4x);
    write_reg(lu24_pkg::CfgSrcWide, 2'b00);
    write_reg(lu24_pkg::CfgOutWide, 2'b00);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'hFF00, 1'b1);
  endtask

  // Bytes widened to signed 16-bit
  task automatic test_widening();
    wait_idle();
    write_reg(lu24_pkg::CfgOutWide, 2'b01);
    send_sample(16'h0080, 1'b0);
    send_sample(16'h007F, 1'b0);
    send_sample(16'h0001, 1'b1);
  endtask

  // Signed 16-bit source at 2x, signed extremes
  task automatic test_wide_source_2x();
    wait_idle();
    write_reg(lu24_pkg::CfgSrcWide, 2'b01);
    write_reg(lu24_pkg::CfgRate, lu24_pkg::Rate2x);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
  endtask

  // Held bits reread under a new format, rate code three as 4x
  task automatic test_mid_sound_change();
    wait_idle();
    send_sample(16'h00C3, 1'b0);
    wait_idle();
    write_reg(lu24_pkg::CfgSrcWide, 2'b10);
    write_reg(lu24_pkg::CfgRate, 2'b11);
    send_sample(16'h0011, 1'b1);
  endtask

  // Write to the spare index, then plain 1x copy
  task automatic test_spare_index();
    wait_idle();
    write_reg(CfgSpare, 2'b11);
    write_reg(lu24_pkg::CfgRate, lu24_pkg::Rate1x);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
  endtask

  // Short random sounds, some left open across a register change
  task automatic test_random_sounds(input int unsigned src_idle, input int unsigned dst_stall);
    int unsigned sent;
    int unsigned len;
    logic [15:0] bits;
    bit complete;
    sent = 0;
    idle_pct = src_idle;
    stall_pct = dst_stall;
    while (sent < PhaseItems) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        write_reg(lu24_pkg::CfgRate, 2'($urandom_range(0, 3)));
        write_reg(lu24_pkg::CfgSrcWide, 2'($urandom_range(0, 3)));
        write_reg(lu24_pkg::CfgOutWide, 2'($urandom_range(0, 3)));
      end
      len = $urandom_range(1, 6);
      complete = ($urandom_range(0, 5) != 0);
      for (int unsigned k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0:       bits = 16'h0000;
          1:       bits = 16'hFFFF;
          2:       bits = 16'h8000;
          3:       bits = 16'h7FFF;
          4:       bits = 16'h0080;
          default: bits = 16'($urandom);
        endcase
        send_sample(bits, complete && (k == len - 1));
        sent++;
      end
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected result, expected none, got bits %h run_end %b",
                 $time, res_if.out_bits, res_if.run_end);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (res_if.out_bits !== want.bits) begin
          $display("%0t: out_bits mismatch, expected %h, got %h",
                   $time, want.bits, res_if.out_bits);
          errors++;
        end
        if (res_if.run_end !== want.last) begin
          $display("%0t: run_end mismatch, expected %b, got %b",
                   $time, want.last, res_if.run_end);
          errors++;
        end
      end
    end
  end

  // Abandon the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sequence the tests
  initial begin
    errors = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    pred_rate = lu24_pkg::Rate1x;
    pred_src_wide = 1'b0;
    pred_out_wide = 1'b0;
    held_raw = 16'h0000;
    held_live = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.sample_bits = 16'h0000;
    smp_if.is_final = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lu24_pkg::CfgRate;
    cfg_if.data = 2'b00;
    res_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_final();
    test_narrow_4x();
    test_widening();
    test_wide_source_2x();
    test_mid_sound_change();
    test_spare_index();
    test_random_sounds(0, 0);
    test_random_sounds(66, 0);
    test_random_sounds(0, 66);
    test_random_sounds(38, 38);
    wait_idle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/lu24_pkg.sv
sv/lu24_if.sv
sv/lu24_front.sv
sv/lu24_queue.sv
sv/lu24_back.sv
sv/linear_upsampler_2x_4x.sv
dv/tb.sv
